/* hdl/bus_io_port_controller_top_defines.svh */
// assertion macros used by the asserting module, bio_core
`ifndef BUS_IO_PORT_CONTROLLER_TOP_DEFINES_SVH
`define BUS_IO_PORT_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BIO_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BIO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bio_pkg.sv */
package bio_pkg;

  localparam int unsigned NUM_PORTS = 7;

  // register offsets
  localparam logic [3:0] OFS_PORT_A = 4'h0;
  localparam logic [3:0] OFS_PORT_G = 4'h6;
  localparam logic [3:0] OFS_DIR    = 4'h8;
  localparam logic [3:0] OFS_TX     = 4'hA;
  localparam logic [3:0] OFS_RX     = 4'hC;
  localparam logic [3:0] OFS_ID     = 4'hD;
  localparam logic [3:0] OFS_MODE   = 4'hE;
  localparam logic [3:0] OFS_ANALOG = 4'hF;

  // fixed read values
  localparam logic [7:0] ID_VALUE      = 8'h0C;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;
  localparam logic [7:0] ANALOG_ABSENT = 8'h00;

  // access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [3:0] offset;
    logic [7:0] write_data;
    logic [7:0] source_data;
    logic       source_present;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_drive_valid;
    logic [2:0] port_drive_index;
    logic [7:0] drive_value;
    logic       serial_tx_valid;
    logic [2:0] analog_channel_used;
    logic [7:0] mode_value;
  } result_t;

endpackage

/* hdl/bio_in_stage.sv */
module bio_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [3:0]       offset,
  input  logic [7:0]       write_data,
  input  logic [7:0]       source_data,
  input  logic             source_present,
  input  logic             take,
  output logic             stage_valid,
  output bio_pkg::access_t stage_access
);
  import bio_pkg::*;

  logic load;

  // room out of reset when empty or when the held transaction moves on this cycle
  assign in_ready = !rst && (!stage_valid || take);
  assign load     = in_valid && in_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  // captured access
  always_ff @(posedge clk) begin
    if (load) begin
      stage_access.mode           <= mode;
      stage_access.offset         <= offset;
      stage_access.write_data     <= write_data;
      stage_access.source_data    <= source_data;
      stage_access.source_present <= source_present;
    end
  end

endmodule

/* hdl/bio_core.sv */
`include "bus_io_port_controller_top_defines.svh"

module bio_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  bio_pkg::access_t acc,
  output bio_pkg::result_t res
);
  import bio_pkg::*;

  logic [7:0] port_latches [NUM_PORTS];
  logic [7:0] direction_bits;
  logic [7:0] mode_register;
  logic [2:0] analog_channel;

  logic [2:0] port_idx;
  logic [7:0] source_or_open;

  assign port_idx       = acc.offset[2:0];
  assign source_or_open = acc.source_present ? acc.source_data : OPEN_BUS;

  // access decode and result
  always_comb begin
    res.read_data           = OPEN_BUS;
    res.port_drive_valid    = 1'b0;
    res.port_drive_index    = 3'd0;
    res.drive_value         = 8'd0;
    res.serial_tx_valid     = 1'b0;
    res.analog_channel_used = 3'd0;
    res.mode_value          = mode_register;
    if (acc.mode == MODE_READ) begin
      unique case (acc.offset) inside
        [OFS_PORT_A:OFS_PORT_G]: begin
          res.read_data = direction_bits[port_idx] ? source_or_open : port_latches[port_idx];
        end
        OFS_RX: begin
          res.read_data = source_or_open;
        end
        OFS_ID: begin
          res.read_data = ID_VALUE;
        end
        OFS_ANALOG: begin
          res.analog_channel_used = analog_channel;
          res.read_data = acc.source_present ? acc.source_data : ANALOG_ABSENT;
        end
        default: begin
          res.read_data = OPEN_BUS;
        end
      endcase
    end else begin
      unique case (acc.offset) inside
        [OFS_PORT_A:OFS_PORT_G]: begin
          res.port_drive_valid = 1'b1;
          res.port_drive_index = port_idx;
          res.drive_value      = acc.write_data;
        end
        OFS_TX: begin
          res.serial_tx_valid = 1'b1;
          res.drive_value     = acc.write_data;
        end
        OFS_MODE: begin
          res.mode_value = acc.write_data;
        end
        default: begin
          res.port_drive_valid = 1'b0;
        end
      endcase
    end
  end

  // port latches, written on port writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_latches[i] <= 8'd0;
      end
    end else if (commit && res.port_drive_valid) begin
      port_latches[port_idx] <= acc.write_data;
    end
  end

  // direction, mode and analog channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_bits <= 8'd0;
      mode_register  <= 8'd0;
      analog_channel <= 3'd0;
    end else if (commit) begin
      mode_register <= res.mode_value;
      if (acc.mode == MODE_WRITE && acc.offset == OFS_DIR) begin
        direction_bits <= acc.write_data;
      end
      if (acc.offset == OFS_ANALOG) begin
        if (acc.mode == MODE_WRITE) begin
          analog_channel <= acc.write_data[2:0];
        end else begin
          analog_channel <= analog_channel + 3'd1;
        end
      end
    end
  end

  `BIO_ASSERT_NEXT(a_chan_advance, clk, rst,
    commit && acc.mode == MODE_READ && acc.offset == OFS_ANALOG,
    analog_channel == $past(analog_channel) + 3'd1, "analog channel did not advance")
  `BIO_ASSERT_NEXT(a_idle_holds, clk, rst, !commit,
    $stable(analog_channel) && $stable(direction_bits) && $stable(mode_register),
    "state changed without a transaction")
  `BIO_ASSERT_IMPLY(a_one_drive, clk, rst, 1'b1,
    !(res.port_drive_valid && res.serial_tx_valid) && res.port_drive_index != 3'd7,
    "conflicting drive outputs")
  `BIO_ASSERT_NEXT(a_latch_written, clk, rst, commit && res.port_drive_valid,
    port_latches[$past(port_idx)] == $past(acc.write_data), "port latch not written")

endmodule

/* hdl/bio_out_stage.sv */
module bio_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bio_pkg::result_t res_in,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output bio_pkg::result_t res_out
);
  import bio_pkg::*;

  // the register can accept a new result when empty or being drained
  assign take = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* hdl/bus_io_port_controller_top.sv */
// channel | handshake             | payload
// in      | in_valid / in_ready   | mode, offset, write_data, source_data, source_present
// out     | out_valid / out_ready | read_data .. mode_value, the seven result fields
//
// one transaction per cycle sustained while out_ready stays high
// the input register feeds one level of decode into the state and result registers
// reset clears all port latches, direction, mode and analog channel at once
// in_ready is low during reset
// a stalled result is held while one more transaction waits in the input register
module bus_io_port_controller_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [3:0] offset,
  input  logic [7:0] write_data,
  input  logic [7:0] source_data,
  input  logic       source_present,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       port_drive_valid,
  output logic [2:0] port_drive_index,
  output logic [7:0] drive_value,
  output logic       serial_tx_valid,
  output logic [2:0] analog_channel_used,
  output logic [7:0] mode_value
);
  import bio_pkg::*;

  logic    take;
  logic    stage_valid;
  logic    commit;
  access_t stage_access;
  result_t core_res;
  result_t out_res;

  assign commit = stage_valid && take;

  // input register
  bio_in_stage u_in_stage (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .offset         (offset),
    .write_data     (write_data),
    .source_data    (source_data),
    .source_present (source_present),
    .take           (take),
    .stage_valid    (stage_valid),
    .stage_access   (stage_access)
  );

  // register file and access decode
  bio_core u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .acc    (stage_access),
    .res    (core_res)
  );

  // result register
  bio_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (commit),
    .res_in    (core_res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  // result fields
  assign read_data           = out_res.read_data;
  assign port_drive_valid    = out_res.port_drive_valid;
  assign port_drive_index    = out_res.port_drive_index;
  assign drive_value         = out_res.drive_value;
  assign serial_tx_valid     = out_res.serial_tx_valid;
  assign analog_channel_used = out_res.analog_channel_used;
  assign mode_value          = out_res.mode_value;

endmodule
